### sv/header_length_packet_deframer_macros.svh
// Assertion macros for the header/length packet deframer checker.
// Each macro expects clk and arst_n to be visible where it is used.
`ifndef HEADER_LENGTH_PACKET_DEFRAMER_MACROS_SVH
`define HEADER_LENGTH_PACKET_DEFRAMER_MACROS_SVH

// Same-cycle implication, disabled during reset
`define HLPD_ASSERT_IMP(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, disabled during reset
`define HLPD_ASSERT_NXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

### sv/hlpd_pkg.sv
// Shared types and constants for the header/length packet deframer.
// No dependencies.
package hlpd_pkg;

	localparam int BYTE_W    = 8;
	localparam int IDX_OUT_W = 5;
	localparam int ERR_W     = 16;
	localparam int S_TDATA_W = 8;
	localparam int S_TUSER_W = 1;
	localparam int M_TDATA_W = 64;
	localparam int M_TUSER_W = 2;
	localparam int REG_IDX_W = 1;

	localparam logic [REG_IDX_W-1:0] REG_HEADER_FIRST  = 1'b0;
	localparam logic [REG_IDX_W-1:0] REG_HEADER_SECOND = 1'b1;

	localparam logic [BYTE_W-1:0] HEADER_FIRST_RST  = 8'd65;
	localparam logic [BYTE_W-1:0] HEADER_SECOND_RST = 8'd87;

	// controller -> datapath
	typedef struct packed {
		logic ovr;       // count an overrun
		logic cap_cmd;   // hold the command byte
		logic cap_len;   // hold the length byte, clear the byte counter
		logic wr_data;   // store a payload byte, advance the counter
		logic cap_chk1;  // hold the first check byte
		logic cap_chk2;  // hold the second check byte
		logic rd_clear;  // rewind the read pointer
		logic rd_issue;  // read the store at the read pointer
		logic rd_next;   // advance the read pointer
		logic ld_data;   // load a data result into the output register
		logic ld_empty;  // load the single no-data result
	} hlpd_cmd_t;

	// datapath -> controller
	typedef struct packed {
		logic hdr1_hit;  // incoming byte equals header_first
		logic hdr2_hit;  // incoming byte equals header_second
		logic in_zero;   // incoming byte is zero
		logic data_done; // this payload byte is the last one
		logic no_store;  // held length is zero or too large
		logic rd_last;   // read pointer is at the final payload byte
		logic out_free;  // output register can take a word this cycle
	} hlpd_sts_t;

endpackage

### sv/hlpd_ram.sv
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module hlpd_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 32
) (
	input  logic                                   clk,
	input  logic                                   wr_en,
	input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] wr_addr,
	input  logic [WIDTH-1:0]                       wr_data,
	input  logic                                   rd_en,
	input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] rd_addr,
	output logic [WIDTH-1:0]                       rd_data
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_q[wr_addr] <= wr_data;
		end
		if (rd_en) begin
			rd_data <= mem_q[rd_addr];
		end
	end

endmodule

### sv/hlpd_ctrl.sv
// Parse and drain controller for the packet deframer.
// Depends on hlpd_pkg for the command and status structs.
module hlpd_ctrl (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              s_tvalid,
	input  logic              overrun,
	input  hlpd_pkg::hlpd_sts_t sts,
	output hlpd_pkg::hlpd_cmd_t cmd,
	output logic              s_tready
);

	import hlpd_pkg::*;

	typedef enum logic [3:0] {
		ST_HUNT1, ST_HUNT2, ST_CMD, ST_LEN, ST_DATA, ST_CHK1, ST_CHK2,
		ST_RD, ST_LD, ST_ONE
	} state_t;

	state_t state_q, state_nxt, eff_phase;
	logic   rdy_q;
	logic   acc;

	assign s_tready = rdy_q;
	assign acc      = s_tvalid && rdy_q;

	always_comb begin
		cmd       = '0;
		state_nxt = state_q;
		eff_phase = overrun ? ST_HUNT1 : state_q;
		if (acc) begin
			cmd.ovr = overrun;
			case (eff_phase)
				ST_HUNT1: state_nxt = sts.hdr1_hit ? ST_HUNT2 : ST_HUNT1;
				ST_HUNT2: state_nxt = sts.hdr2_hit ? ST_CMD : ST_HUNT1;
				ST_CMD: begin
					cmd.cap_cmd = 1'b1;
					state_nxt   = ST_LEN;
				end
				ST_LEN: begin
					cmd.cap_len = 1'b1;
					state_nxt   = sts.in_zero ? ST_CHK1 : ST_DATA;
				end
				ST_DATA: begin
					cmd.wr_data = 1'b1;
					state_nxt   = sts.data_done ? ST_CHK1 : ST_DATA;
				end
				ST_CHK1: begin
					cmd.cap_chk1 = 1'b1;
					state_nxt    = ST_CHK2;
				end
				ST_CHK2: begin
					cmd.cap_chk2 = 1'b1;
					cmd.rd_clear = 1'b1;
					state_nxt    = sts.no_store ? ST_ONE : ST_RD;
				end
				default: state_nxt = ST_HUNT1;
			endcase
		end else begin
			case (state_q)
				ST_RD: begin
					cmd.rd_issue = 1'b1;
					state_nxt    = ST_LD;
				end
				ST_LD: begin
					if (sts.out_free) begin
						cmd.ld_data = 1'b1;
						if (sts.rd_last) begin
							state_nxt = ST_HUNT1;
						end else begin
							cmd.rd_next = 1'b1;
							state_nxt   = ST_RD;
						end
					end
				end
				ST_ONE: begin
					if (sts.out_free) begin
						cmd.ld_empty = 1'b1;
						state_nxt    = ST_HUNT1;
					end
				end
				default: state_nxt = state_q;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_HUNT1;
			rdy_q   <= 1'b1;
		end else begin
			state_q <= state_nxt;
			rdy_q   <= (state_nxt inside {[ST_HUNT1:ST_CHK2]});
		end
	end

endmodule

### sv/hlpd_dp.sv
// Datapath of the packet deframer: header registers, held fields, payload store,
// read pointer and output register. Depends on hlpd_pkg and hlpd_ram.
module hlpd_dp #(
	parameter int MAX_PAYLOAD = 32
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                cfg_we,
	input  logic [hlpd_pkg::REG_IDX_W-1:0]      cfg_index,
	input  logic [hlpd_pkg::BYTE_W-1:0]         cfg_data,
	input  logic [hlpd_pkg::BYTE_W-1:0]         in_byte,
	input  hlpd_pkg::hlpd_cmd_t                 cmd,
	output hlpd_pkg::hlpd_sts_t                 sts,
	input  logic                                out_ready,
	output logic                                out_valid,
	output logic [hlpd_pkg::BYTE_W-1:0]         command_code,
	output logic [hlpd_pkg::BYTE_W-1:0]         payload_length,
	output logic [hlpd_pkg::BYTE_W-1:0]         check_first,
	output logic [hlpd_pkg::BYTE_W-1:0]         check_second,
	output logic [hlpd_pkg::IDX_OUT_W-1:0]      byte_index,
	output logic [hlpd_pkg::BYTE_W-1:0]         data_byte,
	output logic                                has_data,
	output logic                                oversize,
	output logic                                last,
	output logic [hlpd_pkg::ERR_W-1:0]          error_total
);

	import hlpd_pkg::*;

	localparam int          ADDR_W = (MAX_PAYLOAD > 1) ? $clog2(MAX_PAYLOAD) : 1;
	localparam logic [8:0]  MAX_V  = 9'(MAX_PAYLOAD);

	logic [BYTE_W-1:0] hdr_first_q, hdr_second_q;
	logic [BYTE_W-1:0] held_cmd_q, held_len_q, byte_cnt_q, chk1_q, chk2_q;
	logic [ERR_W-1:0]  err_cnt_q;
	logic [ADDR_W-1:0] rd_idx_q;
	logic [BYTE_W-1:0] ram_rdata;
	logic              len_over, ram_we;
	logic [8:0]        cnt_inc, rd_inc;
	logic [7:0]        rd_idx8;

	assign len_over = {1'b0, held_len_q} > MAX_V;
	assign cnt_inc  = {1'b0, byte_cnt_q} + 9'd1;
	assign rd_inc   = 9'(rd_idx_q) + 9'd1;
	assign rd_idx8  = 8'(rd_idx_q);
	assign ram_we   = cmd.wr_data && !len_over && ({1'b0, byte_cnt_q} < MAX_V);

	assign sts.hdr1_hit  = (in_byte == hdr_first_q);
	assign sts.hdr2_hit  = (in_byte == hdr_second_q);
	assign sts.in_zero   = (in_byte == '0);
	assign sts.data_done = (cnt_inc >= {1'b0, held_len_q});
	assign sts.no_store  = (held_len_q == '0) || len_over;
	assign sts.rd_last   = (rd_inc == {1'b0, held_len_q});
	assign sts.out_free  = !out_valid || out_ready;

	hlpd_ram #(
		.WIDTH (BYTE_W),
		.DEPTH (MAX_PAYLOAD)
	) u_store (
		.clk     (clk),
		.wr_en   (ram_we),
		.wr_addr (byte_cnt_q[ADDR_W-1:0]),
		.wr_data (in_byte),
		.rd_en   (cmd.rd_issue),
		.rd_addr (rd_idx_q),
		.rd_data (ram_rdata)
	);

	// configuration, held fields, counters
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			hdr_first_q  <= HEADER_FIRST_RST;
			hdr_second_q <= HEADER_SECOND_RST;
			held_cmd_q   <= '0;
			held_len_q   <= '0;
			byte_cnt_q   <= '0;
			chk1_q       <= '0;
			chk2_q       <= '0;
			err_cnt_q    <= '0;
			rd_idx_q     <= '0;
		end else begin
			if (cfg_we && cfg_index == REG_HEADER_FIRST)  hdr_first_q  <= cfg_data;
			if (cfg_we && cfg_index == REG_HEADER_SECOND) hdr_second_q <= cfg_data;
			if (cmd.ovr)      err_cnt_q  <= err_cnt_q + 1'b1;
			if (cmd.cap_cmd)  held_cmd_q <= in_byte;
			if (cmd.cap_len) begin
				held_len_q <= in_byte;
				byte_cnt_q <= '0;
			end
			if (cmd.wr_data)  byte_cnt_q <= cnt_inc[BYTE_W-1:0];
			if (cmd.cap_chk1) chk1_q     <= in_byte;
			if (cmd.cap_chk2) chk2_q     <= in_byte;
			if (cmd.rd_clear) begin
				rd_idx_q <= '0;
			end else if (cmd.rd_next) begin
				rd_idx_q <= rd_inc[ADDR_W-1:0];
			end
		end
	end

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid <= 1'b0;
		end else if (cmd.ld_data || cmd.ld_empty) begin
			out_valid <= 1'b1;
		end else if (out_ready) begin
			out_valid <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.ld_data || cmd.ld_empty) begin
			command_code   <= held_cmd_q;
			payload_length <= held_len_q;
			check_first    <= chk1_q;
			check_second   <= chk2_q;
			error_total    <= err_cnt_q;
			byte_index     <= cmd.ld_data ? rd_idx8[IDX_OUT_W-1:0] : '0;
			data_byte      <= cmd.ld_data ? ram_rdata : '0;
			has_data       <= cmd.ld_data;
			oversize       <= cmd.ld_empty && len_over;
			last           <= cmd.ld_empty || sts.rd_last;
		end
	end

endmodule

### sv/header_length_packet_deframer.sv
// Header, command, length, payload and check bytes are each taken when offered while s_tready
// is high. After the last check byte, each result word in turn is read from the payload store
// into registered read data and then loaded into the output register once that is free; an
// empty or oversized packet loads its single no-data word without a read. Input is held off
// while a packet drains, plus any time a word waits on m_tready.
// Reset (arst_n low, asynchronous) restarts the hunt, clears counters and held fields and
// restores the header bytes to 'A' and 'W'; the payload store is not cleared.
module header_length_packet_deframer #(
	parameter int MAX_PAYLOAD = 32  // payload store depth, 1 to 32
) (
	input  logic                                clk,
	input  logic                                arst_n,
	// configuration: index 0 header_first, index 1 header_second
	input  logic                                cfg_we,
	input  logic [hlpd_pkg::REG_IDX_W-1:0]      cfg_index,
	input  logic [hlpd_pkg::BYTE_W-1:0]         cfg_data,
	// received bytes
	input  logic                                s_tvalid,
	output logic                                s_tready,
	input  logic [hlpd_pkg::S_TDATA_W-1:0]      s_tdata,   // [7:0] in_byte
	input  logic [hlpd_pkg::S_TUSER_W-1:0]      s_tuser,   // [0] overrun
	// packet results
	output logic                                m_tvalid,
	input  logic                                m_tready,
	// [7:0] command_code, [15:8] payload_length, [23:16] check_first,
	// [31:24] check_second, [36:32] byte_index, [44:37] data_byte,
	// [60:45] error_total, [63:61] zero
	output logic [hlpd_pkg::M_TDATA_W-1:0]      m_tdata,
	output logic [hlpd_pkg::M_TUSER_W-1:0]      m_tuser,   // [0] has_data, [1] oversize
	output logic                                m_tlast
);

	import hlpd_pkg::*;

	hlpd_cmd_t         cmd;
	hlpd_sts_t         sts;
	logic [BYTE_W-1:0] command_code, payload_length, check_first, check_second;
	logic [BYTE_W-1:0] data_byte;
	logic [IDX_OUT_W-1:0] byte_index;
	logic [ERR_W-1:0]  error_total;
	logic              has_data, oversize;

	// The controller walks the packet grammar one byte per accepted word. An overrun
	// flag counts an error and drops the parser back to the first header hunt before
	// the byte itself is looked at, so that byte may start a new header.
	hlpd_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.overrun  (s_tuser[0]),
		.sts      (sts),
		.cmd      (cmd),
		.s_tready (s_tready)
	);

	// The datapath holds the packet fields and the payload store. Bytes of a packet
	// whose length exceeds the store are counted but not written, and the packet is
	// reported as a single oversized word. The output register parts the drain from
	// the consumer, so the hunt restarts while the final word still waits.
	hlpd_dp #(
		.MAX_PAYLOAD (MAX_PAYLOAD)
	) u_dp (
		.clk            (clk),
		.arst_n         (arst_n),
		.cfg_we         (cfg_we),
		.cfg_index      (cfg_index),
		.cfg_data       (cfg_data),
		.in_byte        (s_tdata[BYTE_W-1:0]),
		.cmd            (cmd),
		.sts            (sts),
		.out_ready      (m_tready),
		.out_valid      (m_tvalid),
		.command_code   (command_code),
		.payload_length (payload_length),
		.check_first    (check_first),
		.check_second   (check_second),
		.byte_index     (byte_index),
		.data_byte      (data_byte),
		.has_data       (has_data),
		.oversize       (oversize),
		.last           (m_tlast),
		.error_total    (error_total)
	);

	// pack the result word, first field lowest
	assign m_tdata = {3'b000, error_total, data_byte, byte_index, check_second,
		check_first, payload_length, command_code};
	assign m_tuser = {oversize, has_data};

endmodule

### sv/hlpd_checker.sv
// Port-level checks on the packet deframer, bound to the top level.
// Depends on header_length_packet_deframer_macros.svh and hlpd_pkg.
`include "header_length_packet_deframer_macros.svh"

module hlpd_checker (
	input logic                               clk,
	input logic                               arst_n,
	input logic                               m_tvalid,
	input logic                               m_tready,
	input logic [hlpd_pkg::M_TDATA_W-1:0]     m_tdata,
	input logic [hlpd_pkg::M_TUSER_W-1:0]     m_tuser,
	input logic                               m_tlast
);

	// a stalled result word stays offered
	`HLPD_ASSERT_NXT(a_hold_valid, m_tvalid && !m_tready, m_tvalid, "result word dropped while stalled")

	// a word never carries payload and the oversize mark together
	`HLPD_ASSERT_IMP(a_data_xor_over, m_tvalid, !(m_tuser[0] && m_tuser[1]), "has_data with oversize")

	// an oversized packet is reported as a single, final word
	`HLPD_ASSERT_IMP(a_over_last, m_tvalid && m_tuser[1], m_tlast, "oversize word without last")

	// a word without payload has zero index and zero data
	`HLPD_ASSERT_IMP(a_empty_zero, m_tvalid && !m_tuser[0], m_tdata[44:32] == 13'd0, "no-data word not zeroed")

endmodule

bind header_length_packet_deframer hlpd_checker u_hlpd_checker (
	.clk      (clk),
	.arst_n   (arst_n),
	.m_tvalid (m_tvalid),
	.m_tready (m_tready),
	.m_tdata  (m_tdata),
	.m_tuser  (m_tuser),
	.m_tlast  (m_tlast)
);
